// File: hw/rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants of the paged address translator
// Geometry of the page table, item layouts and controller/datapath links.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int PAGE_WORDS  = 8;
	localparam int PAGE_COUNT  = 64;
	localparam int FRAME_COUNT = 16;

	localparam int ADDR_W   = 10;
	localparam int OFFSET_W = $clog2(PAGE_WORDS);
	localparam int PAGE_W   = $clog2(PAGE_COUNT);
	localparam int FRAME_W  = $clog2(FRAME_COUNT);
	localparam int PHYS_W   = 7;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 32;
	localparam int WIN_W    = 16;

	// first address past the table
	localparam logic [ADDR_W:0] ADDR_SPAN = (ADDR_W + 1)'(PAGE_WORDS * PAGE_COUNT);

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(20);

	// configuration register word indexes
	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_MAP   = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [ADDR_W-1:0]      address;
		logic signed [DATA_W-1:0] write_data;
		logic [5:0]             page;
		logic [3:0]             frame;
		logic                   present;
		logic                   clear_ref;
	} req_t;

	typedef struct packed {
		logic                   fault;
		logic                   out_of_range;
		logic [PHYS_W-1:0]      phys_addr;
		logic                   write_enable;
		logic signed [DATA_W-1:0] data_out;
		logic                   window_elapsed;
		logic [COUNT_W-1:0]     access_count;
		logic [5:0]             fault_page;
		logic                   entry_present;
		logic                   entry_ref;
		logic                   entry_dirty;
		logic [3:0]             entry_frame;
	} rsp_t;

	// one page table entry as stored in the table RAM
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               present;
		logic               referenced;
		logic               dirty;
	} pte_t;

	localparam int ENTRY_W = $bits(pte_t);

	typedef struct packed {
		logic lookup;   // take the request item and start the table read
		logic commit;   // finish the item: update table, counters, result
	} pat_cmd_t;

	typedef struct packed {
		logic out_full; // result register holds an item not yet taken
		logic out_take; // that item is taken at this edge
	} pat_sts_t;

endpackage

// File: hw/rtl/pat_ram.sv
// ----------------------------------------------------------------------------
// pat_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/pat_ctrl.sv
// ----------------------------------------------------------------------------
// pat_ctrl: translator control sequencer
// Takes one item, waits for the table read, then commits once the result
// register can take the result.
// ----------------------------------------------------------------------------
module pat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  pat_pkg::pat_sts_t sts,
	output pat_pkg::pat_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign req_stall  = busy_q;
	assign cmd.lookup = (state_q == ST_IDLE) && req_valid;
	// commit when the result register is empty or drains at this edge
	assign cmd.commit = (state_q == ST_LOOK) && (!sts.out_full || sts.out_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.lookup) begin
						state_q <= ST_LOOK;
						busy_q  <= 1'b1;
					end
				end
				ST_LOOK: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/pat_dp.sv
// ----------------------------------------------------------------------------
// pat_dp: translator datapath
// Page table RAM with entry valid bits, access and window counters,
// the window register and the result register.
// ----------------------------------------------------------------------------
module pat_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pat_pkg::req_t                req,
	input  pat_pkg::pat_cmd_t            cmd,
	output pat_pkg::pat_sts_t            sts,
	input  logic                         win_we,
	input  logic [pat_pkg::WIN_W-1:0]    win_wdata,
	output logic [pat_pkg::WIN_W-1:0]    window_len,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output pat_pkg::rsp_t                rsp
);

	pat_pkg::req_t                 item_q;
	logic [pat_pkg::PAGE_W-1:0]    idx_q;
	logic [pat_pkg::PAGE_COUNT-1:0] valid_q;
	logic [pat_pkg::COUNT_W-1:0]   total_q;
	logic [pat_pkg::WIN_W-1:0]     wpos_q;
	logic [pat_pkg::WIN_W-1:0]     win_q;
	logic                          out_valid_q;
	pat_pkg::rsp_t                 out_q;

	logic [pat_pkg::PAGE_W-1:0]    rd_idx;
	logic [pat_pkg::ENTRY_W-1:0]   ram_rdata;
	pat_pkg::pte_t                 entry;
	pat_pkg::pte_t                 new_entry;
	pat_pkg::rsp_t                 result;
	logic                          is_acc;
	logic                          is_write;
	logic                          is_map;
	logic                          is_query;
	logic                          oor;
	logic                          good;
	logic                          tbl_we;
	logic [pat_pkg::COUNT_W-1:0]   total_next;
	logic [pat_pkg::WIN_W:0]       wpos_inc;
	logic                          win_done;

	// accesses index by virtual page, map and query by the page field
	always_comb begin
		if (req.kind == pat_pkg::KIND_READ || req.kind == pat_pkg::KIND_WRITE) begin
			rd_idx = req.address[pat_pkg::OFFSET_W +: pat_pkg::PAGE_W];
		end else begin
			rd_idx = req.page;
		end
	end

	pat_ram #(
		.WIDTH(pat_pkg::ENTRY_W),
		.DEPTH(pat_pkg::PAGE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(idx_q),
		.wdata(new_entry),
		.re   (cmd.lookup),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	// entries never mapped read as cleared
	assign entry = valid_q[idx_q] ? pat_pkg::pte_t'(ram_rdata) : '0;

	assign is_write = (item_q.kind == pat_pkg::KIND_WRITE);
	assign is_acc   = (item_q.kind == pat_pkg::KIND_READ) || is_write;
	assign is_map   = (item_q.kind == pat_pkg::KIND_MAP);
	assign is_query = (item_q.kind == pat_pkg::KIND_QUERY);
	assign oor      = is_acc && ({1'b0, item_q.address} >= pat_pkg::ADDR_SPAN);
	assign good     = is_acc && !oor && entry.present;

	assign wpos_inc   = {1'b0, wpos_q} + (pat_pkg::WIN_W + 1)'(1);
	assign win_done   = wpos_inc >= {1'b0, win_q};
	assign total_next = good ? total_q + pat_pkg::COUNT_W'(1) : total_q;

	always_comb begin
		new_entry = entry;
		if (is_map) begin
			new_entry.frame      = item_q.frame;
			new_entry.present    = item_q.present;
			new_entry.referenced = 1'b0;
			new_entry.dirty      = 1'b0;
		end else if (is_query) begin
			new_entry.referenced = 1'b0;
		end else begin
			new_entry.referenced = 1'b1;
			new_entry.dirty      = entry.dirty | is_write;
		end
	end

	assign tbl_we = cmd.commit && (good || is_map || (is_query && item_q.clear_ref));

	always_comb begin
		result                = '0;
		result.out_of_range   = oor;
		result.fault          = is_acc && !oor && !entry.present;
		result.access_count   = total_next;
		result.window_elapsed = good && win_done;
		if (good) begin
			result.phys_addr = pat_pkg::PHYS_W'({entry.frame,
				item_q.address[pat_pkg::OFFSET_W-1:0]});
		end
		if (good && is_write) begin
			result.write_enable = 1'b1;
			result.data_out     = item_q.write_data;
		end
		if (is_acc && !oor) begin
			result.fault_page = idx_q;
		end
		if (is_map || is_query) begin
			result.fault_page = item_q.page;
		end
		if (is_query) begin
			result.entry_present = entry.present;
			result.entry_ref     = entry.referenced;
			result.entry_dirty   = entry.dirty;
			result.entry_frame   = entry.frame;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			item_q <= req;
			idx_q  <= rd_idx;
		end
		if (cmd.commit) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			total_q     <= '0;
			wpos_q      <= '0;
			win_q       <= pat_pkg::WINDOW_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (win_we) begin
				win_q <= win_wdata;
			end
			if (cmd.commit && is_map) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.commit && good) begin
				total_q <= total_next;
				wpos_q  <= win_done ? '0 : wpos_inc[pat_pkg::WIN_W-1:0];
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_full = out_valid_q;
	assign sts.out_take = out_valid_q && !rsp_stall;
	assign rsp_valid    = out_valid_q;
	assign rsp          = out_q;
	assign window_len   = win_q;

endmodule

// File: hw/rtl/paged_address_translator_top.sv
// ----------------------------------------------------------------------------
// paged_address_translator_top: page table address translator
// Translates read and write accesses through a 64-entry page table and
// maintains referenced/dirty bits, an access counter and a window flag.
// ----------------------------------------------------------------------------
// Each request item yields exactly one response item. The page table RAM
// is read at the edge that accepts an item; the entry is evaluated in the
// following cycle. Once the result register can take a result, the item
// commits: the entry may be written back and the result is registered.
// The next item is accepted only after the previous one commits, so the
// block takes no new item while one is in flight; each item reads and may
// then write back the single table RAM. A finished result waits in the output
// register while the next item is taken, so a stall on the response side
// only holds the block once a second result is ready. Reads and writes
// translate into frame * 8 + offset; an absent page reports fault with the
// page, an address at or past 512 reports out_of_range, and neither changes
// any state. Map items load frame and present and clear referenced and
// dirty; query items report an entry and may clear its referenced bit.
// No clearing pass runs after reset: per-entry valid bits make unmapped
// entries read as cleared, so the block is ready at the first cycle.
// The window length register sits at byte address 0 of the APB port;
// change it only while no item is in flight.
// ----------------------------------------------------------------------------
module paged_address_translator_top (
	input  logic          clk,
	input  logic          arst_n,
	// configuration port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	// request channel
	input  logic          req_valid,
	output logic          req_stall,
	input  pat_pkg::req_t req,
	// response channel
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pat_pkg::rsp_t rsp
);

	pat_pkg::pat_cmd_t         cmd;
	pat_pkg::pat_sts_t         sts;
	logic                      win_we;
	logic [pat_pkg::WIN_W-1:0] window_len;

	// decode the register word by paddr[2]; the low bits are not decoded
	assign pready = 1'b1;
	assign win_we = psel && penable && pwrite && (paddr[2] == pat_pkg::REG_WINDOW_LEN);

	always_comb begin
		prdata = '0;
		if (paddr[2] == pat_pkg::REG_WINDOW_LEN) begin
			prdata = {{(32 - pat_pkg::WIN_W){1'b0}}, window_len};
		end
	end

	// sequencer: accept, wait for the table read, commit
	pat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, counters and result register
	pat_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cmd        (cmd),
		.sts        (sts),
		.win_we     (win_we),
		.win_wdata  (pwdata[pat_pkg::WIN_W-1:0]),
		.window_len (window_len),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

// File: tb/pat_tb_pkg.sv
// ----------------------------------------------------------------------------
// pat_tb_pkg: translation scoreboard of the paged address translator bench
// Keeps its own page table, access counter and window position, works out the
// response of each accepted request and compares the block's responses in order.
// ----------------------------------------------------------------------------
package pat_tb_pkg;

	import pat_pkg::*;

	class translation_scoreboard;
		logic [FRAME_W-1:0] frame_of [PAGE_COUNT];
		bit                 is_present [PAGE_COUNT];
		bit                 is_referenced [PAGE_COUNT];
		bit                 is_dirty [PAGE_COUNT];
		logic [COUNT_W-1:0] access_total;
		int unsigned        window_pos;
		int unsigned        window_len;
		rsp_t               expected_rsp [$];
		int unsigned        errors;

		function new();
			foreach (frame_of[i]) begin
				frame_of[i]      = '0;
				is_present[i]    = 1'b0;
				is_referenced[i] = 1'b0;
				is_dirty[i]      = 1'b0;
			end
			access_total = '0;
			window_pos   = 0;
			window_len   = WINDOW_RESET;
			errors       = 0;
		endfunction

		function void set_window(logic [WIN_W-1:0] len);
			window_len = len;
		endfunction

		function int unsigned outstanding();
			return expected_rsp.size();
		endfunction

		// work out the response of one request and advance the table state
		function rsp_t translate(req_t r);
			rsp_t                o;
			logic [PAGE_W-1:0]   vp;
			logic [OFFSET_W-1:0] off;
			o = '0;
			case (kind_t'(r.kind))
				KIND_READ, KIND_WRITE: begin
					if ({1'b0, r.address} >= ADDR_SPAN) begin
						o.out_of_range = 1'b1;
					end else begin
						vp = PAGE_W'(r.address / PAGE_WORDS);
						off = OFFSET_W'(r.address % PAGE_WORDS);
						o.fault_page = vp;
						if (!is_present[vp]) begin
							o.fault = 1'b1;
						end else begin
							is_referenced[vp] = 1'b1;
							access_total = access_total + 1'b1;
							// a zero or shrunk window elapses at once
							if (window_pos + 1 >= window_len) begin
								window_pos = 0;
								o.window_elapsed = 1'b1;
							end else begin
								window_pos = window_pos + 1;
							end
							o.phys_addr = PHYS_W'(frame_of[vp] * PAGE_WORDS + off);
							if (kind_t'(r.kind) == KIND_WRITE) begin
								is_dirty[vp] = 1'b1;
								o.write_enable = 1'b1;
								o.data_out = r.write_data;
							end
						end
					end
				end
				KIND_MAP: begin
					o.fault_page = r.page;
					frame_of[r.page]      = r.frame;
					is_present[r.page]    = r.present;
					is_referenced[r.page] = 1'b0;
					is_dirty[r.page]      = 1'b0;
				end
				default: begin
					o.fault_page    = r.page;
					o.entry_present = is_present[r.page];
					o.entry_ref     = is_referenced[r.page];
					o.entry_dirty   = is_dirty[r.page];
					o.entry_frame   = frame_of[r.page];
					if (r.clear_ref)
						is_referenced[r.page] = 1'b0;
				end
			endcase
			o.access_count = access_total;
			return o;
		endfunction

		function void note_request(req_t r);
			expected_rsp.push_back(translate(r));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				$error("response %h arrived with no request outstanding", got);
				errors++;
				return;
			end
			want = expected_rsp.pop_front();
			compare_field("fault", want.fault, got.fault);
			compare_field("out_of_range", want.out_of_range, got.out_of_range);
			compare_field("phys_addr", want.phys_addr, got.phys_addr);
			compare_field("write_enable", want.write_enable, got.write_enable);
			compare_field("data_out", want.data_out, got.data_out);
			compare_field("window_elapsed", want.window_elapsed, got.window_elapsed);
			compare_field("access_count", want.access_count, got.access_count);
			compare_field("fault_page", want.fault_page, got.fault_page);
			compare_field("entry_present", want.entry_present, got.entry_present);
			compare_field("entry_ref", want.entry_ref, got.entry_ref);
			compare_field("entry_dirty", want.entry_dirty, got.entry_dirty);
			compare_field("entry_frame", want.entry_frame, got.entry_frame);
		endfunction
	endclass

endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the paged address translator
// Drives a directed run and then randomized read/write/map/query traffic under
// several window lengths, with bursty requests and a stalling receiver,
// and checks every response field against the translation scoreboard.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import pat_pkg::*;
	import pat_tb_pkg::*;

	localparam int              REQ_W            = $bits(req_t);
	localparam logic [2:0]      WINDOW_LEN_ADDR  = 3'(4 * int'(REG_WINDOW_LEN));
	localparam int              PHASES           = 8;
	localparam int              PHASE_ITEMS      = 106;
	localparam int              SETTLE_CYCLES    = 6;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	translation_scoreboard book = new();

	// stimulus-side view of the table: which pages hold a defined frame and
	// which are present, updated as items are generated
	bit   page_mapped [PAGE_COUNT];
	bit   page_present [PAGE_COUNT];
	req_t retry_queue [$];
	int   burst_left = 0;

	paged_address_translator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: switch between random stall patterns so that stalls land on
	// every phase of the block's accept and commit work, with quiet
	// stretches in between.
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int unsigned stall_tick = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		stall_tick++;
		case (stall_mode)
			STALL_NONE:     rsp_stall <= 1'b0;
			STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 25);
			STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 70);
			STALL_PERIODIC: rsp_stall <= stall_tick[2];
		endcase
	end

	// Observe both channels at the clock edge: note each accepted request
	// first, then check each accepted response against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				book.note_request(req);
			if (rsp_valid && !rsp_stall)
				book.check_response(rsp);
		end
	end

	// Item builders. Fields that the kind ignores carry random bits.
	function automatic req_t noise_item();
		return REQ_W'({$urandom, $urandom});
	endfunction

	function automatic req_t make_access(kind_t kind, int unsigned addr, logic [31:0] data);
		req_t r;
		r = noise_item();
		r.kind = kind;
		r.address = ADDR_W'(addr);
		r.write_data = data;
		return r;
	endfunction

	function automatic req_t make_map(int unsigned pg, int unsigned fr, bit pr);
		req_t r;
		r = noise_item();
		r.kind = KIND_MAP;
		r.page = PAGE_W'(pg);
		r.frame = FRAME_W'(fr);
		r.present = pr;
		page_mapped[pg] = 1'b1;
		page_present[pg] = pr;
		return r;
	endfunction

	function automatic req_t make_query(int unsigned pg, bit clr);
		req_t r;
		r = noise_item();
		r.kind = KIND_QUERY;
		r.page = PAGE_W'(pg);
		r.clear_ref = clr;
		return r;
	endfunction

	// Mostly accesses to present pages; some maps, queries of mapped pages,
	// out-of-range addresses and faults, part of them followed by a map of
	// the page and a retry of the same access.
	function automatic req_t random_request();
		req_t        r;
		int unsigned sel;
		int unsigned pg;
		int unsigned tries;
		kind_t       kind;
		if (retry_queue.size() != 0)
			return retry_queue.pop_front();
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return make_map($urandom_range(0, PAGE_COUNT - 1), $urandom_range(0, FRAME_COUNT - 1),
				$urandom_range(0, 99) < 85);
		if (sel < 20) begin
			// never query an entry whose frame was never written
			pg = $urandom_range(0, PAGE_COUNT - 1);
			for (tries = 0; tries < 64 && !page_mapped[pg]; tries++)
				pg = $urandom_range(0, PAGE_COUNT - 1);
			if (!page_mapped[pg])
				pg = 0;
			return make_query(pg, $urandom_range(0, 1));
		end
		kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return make_access(kind, $urandom_range(PAGE_WORDS * PAGE_COUNT, 1023), $urandom);
		if (sel < 25) begin
			r = make_access(kind, $urandom_range(0, PAGE_WORDS * PAGE_COUNT - 1), $urandom);
			pg = r.address / PAGE_WORDS;
			if (!page_present[pg] && $urandom_range(0, 1)) begin
				retry_queue.push_back(make_map(pg, $urandom_range(0, FRAME_COUNT - 1), 1'b1));
				retry_queue.push_back(r);
			end
			return r;
		end
		pg = $urandom_range(0, PAGE_COUNT - 1);
		for (tries = 0; tries < 16 && !page_present[pg]; tries++)
			pg = $urandom_range(0, PAGE_COUNT - 1);
		return make_access(kind, pg * PAGE_WORDS + $urandom_range(0, PAGE_WORDS - 1), $urandom);
	endfunction

	// Sender: bursts of random length, mostly short, now and then long,
	// separated by random idle gaps. Hold the item until it is taken.
	task automatic push_request(input req_t item);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop sending and wait for every outstanding response, then let the
	// pipeline settle. The wait begins with a clock edge so that the
	// last accepted item has been noted before the count is read.
	task automatic drain_responses();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (book.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_window_len(input logic [WIN_W-1:0] len);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WINDOW_LEN_ADDR;
		pwdata <= 32'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		book.set_window(len);
	endtask

	initial begin
		int unsigned window_plan [PHASES];
		window_plan[0] = 1;
		window_plan[1] = 0;
		window_plan[2] = 65535;
		window_plan[3] = $urandom_range(2, 40);
		window_plan[4] = 3;
		window_plan[5] = $urandom_range(2, 40);
		window_plan[6] = 2;
		window_plan[7] = $urandom_range(5, 60);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run under the reset window length: table extremes,
		// every kind, faults, out-of-range addresses, ref clearing,
		// a retry after mapping and a remap that clears ref and dirty.
		push_request(make_map(0, 15, 1'b1));
		push_request(make_map(PAGE_COUNT - 1, 0, 1'b1));
		push_request(make_map(5, 7, 1'b0));
		push_request(make_access(KIND_READ, 0, 32'h0000_0000));
		push_request(make_access(KIND_WRITE, 511, 32'h7fff_ffff));
		push_request(make_access(KIND_WRITE, 7, 32'h8000_0000));
		push_request(make_access(KIND_READ, 40, 32'h1234_5678));
		push_request(make_access(KIND_WRITE, 512, 32'hdead_beef));
		push_request(make_access(KIND_READ, 1023, 32'hffff_ffff));
		push_request(make_query(0, 1'b0));
		push_request(make_query(0, 1'b1));
		push_request(make_query(0, 1'b0));
		push_request(make_query(PAGE_COUNT - 1, 1'b1));
		push_request(make_query(5, 1'b0));
		push_request(make_map(5, 9, 1'b1));
		push_request(make_access(KIND_READ, 44, 32'h0));
		push_request(make_access(KIND_READ, 80, 32'h0));
		push_request(make_map(0, 3, 1'b1));
		push_request(make_query(0, 1'b1));
		push_request(make_access(KIND_WRITE, 0, 32'h0000_0000));
		push_request(make_access(KIND_WRITE, 504, 32'hffff_ffff));
		push_request(make_query(PAGE_COUNT - 1, 1'b0));

		// Random phases. Before each, hold the sender until every response
		// is back, then change the window length; going from the widest
		// window to a short one shrinks it below the current position.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_responses();
			write_window_len(WIN_W'(window_plan[phase]));
			for (int n = 0; n < PHASE_ITEMS || retry_queue.size() != 0; n++)
				push_request(random_request());
		end

		drain_responses();
		if (book.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pat_pkg.sv
hw/rtl/pat_ram.sv
hw/rtl/pat_ctrl.sv
hw/rtl/pat_dp.sv
hw/rtl/paged_address_translator_top.sv
tb/pat_tb_pkg.sv
tb/tb.sv
